// ===== rtl/core/gbr_pkg.sv =====
`default_nettype none

package gbr_pkg;

  // Display size in pixels; both fit in ten bits so that 512 is representable.
  localparam logic [9:0] DISPLAY_WIDTH  = 10'd240;
  localparam logic [9:0] DISPLAY_HEIGHT = 10'd320;

  // Glyph heights that draw anything, and their byte budgets.
  localparam logic [4:0] HEIGHT_SMALL = 5'd12;
  localparam logic [4:0] HEIGHT_LARGE = 5'd16;

  // Bits in one glyph byte.
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] REG_CHAR_HEIGHT = 2'd0;
  localparam logic [1:0] REG_TRANSPARENT = 2'd1;
  localparam logic [1:0] REG_TEXT_COLOR  = 2'd2;

  localparam logic [4:0]  RST_CHAR_HEIGHT = 5'd16;
  localparam logic [15:0] RST_TEXT_COLOR  = 16'hFFFF;

  typedef struct packed {
    logic accept;  // capture the input item
    logic load;    // apply first-byte handling, decide, build the pixel mask
    logic step;    // walk one glyph bit
  } gbr_cmd_t;

  typedef struct packed {
    logic draw;        // the captured byte produces a pixel walk
    logic emit_block;  // this bit needs the output register, which is full
    logic loop_end;    // this bit is the last one walked for the byte
  } gbr_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/glyph_bitmap_rasterizer_core.sv =====
// Flow: an item is captured when taken, decided in the load state and, if it draws, walked one glyph
// bit per step; a drawn bit loads the output register as it is walked, but the step stalls while that
// register is full and not being drained. A new item is taken only after the walk of the last has
// ended, or straight after the load state when the byte draws nothing.
// Reset: rst_ni is asynchronous and active low; it clears the character state and restores
// char_height to 16, transparent to 0 and text_color to 0xFFFF.
`default_nettype none

module glyph_bitmap_rasterizer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  // Input items: one glyph byte each.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  glyph_bits_i,
  input  wire logic        first_byte_i,
  input  wire logic [8:0]  start_x_i,
  input  wire logic [8:0]  start_y_i,
  // Result items: one pixel write each.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [8:0]       pixel_x_o,
  output logic [8:0]       pixel_y_o,
  output logic [15:0]      pixel_color_o,
  output logic             run_last_o
);

  // The controller sequences each item through capture, a decision cycle and a
  // bit walk. The datapath owns the cursor, the byte budget and the output
  // register, so a finished pixel can wait there while the next bit is walked.
  gbr_pkg::gbr_cmd_t  cmd;
  gbr_pkg::gbr_stat_t stat;

  gbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // In the decision cycle the datapath works out how many bits the byte will
  // walk (bounded by the column end and the bottom edge) and marks the bits
  // that write a pixel. That mark tells each pixel whether it is the last one
  // of its item, without looking ahead during the walk.
  gbr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .glyph_bits_i  (glyph_bits_i),
    .first_byte_i  (first_byte_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .run_last_o    (run_last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/gbr_ctrl.sv =====
`default_nettype none

module gbr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire gbr_pkg::gbr_stat_t stat_i,
  output gbr_pkg::gbr_cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o.accept = in_valid_i && (state_q == ST_IDLE);
    cmd_o.load   = (state_q == ST_LOAD);
    cmd_o.step   = (state_q == ST_STEP);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = stat_i.draw ? ST_STEP : ST_IDLE;
      end
      ST_STEP: begin
        if (!stat_i.emit_block && stat_i.loop_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gbr_datapath.sv =====
`default_nettype none

module gbr_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gbr_pkg::gbr_cmd_t  cmd_i,
  output gbr_pkg::gbr_stat_t      stat_o,
  input  wire logic [7:0]         glyph_bits_i,
  input  wire logic               first_byte_i,
  input  wire logic [8:0]         start_x_i,
  input  wire logic [8:0]         start_y_i,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [8:0]              pixel_x_o,
  output logic [8:0]              pixel_y_o,
  output logic [15:0]             pixel_color_o,
  output logic                    run_last_o
);

  // Configuration registers.
  logic [4:0]  char_height_q;
  logic        transparent_q;
  logic [15:0] text_color_q;

  // Character state.
  logic [8:0] cursor_x_q, cursor_x_d;
  logic [8:0] cursor_y_q, cursor_y_d;
  logic [8:0] column_top_q, column_top_d;
  logic [4:0] bytes_done_q, bytes_done_d;
  logic       char_active_q, char_active_d;

  // Captured item and walk state.
  logic [7:0] bits_q, bits_d;
  logic       first_q;
  logic [8:0] start_x_q, start_y_q;
  logic [7:0] emask_q, emask_d;
  logic [2:0] cnt_q, cnt_d;

  // Output register.
  logic        out_valid_q;
  logic [8:0]  px_q, py_q;
  logic [15:0] pc_q;
  logic        pl_q;

  // Load-cycle terms.
  logic [4:0] total;
  logic [8:0] y_e, top_e;
  logic [4:0] bd_e;
  logic       act_e, draw;
  logic [8:0] d0;
  logic [4:0] col_rem;
  logic [9:0] bot_rem;
  logic [3:0] n_col, n_bot, n_steps;
  logic [7:0] walk_mask;

  // Step-cycle terms.
  logic       emit, out_free, advance, out_load;
  logic [9:0] ny, nx;
  logic [8:0] ny_off;
  logic       bot_hit, col_hit, right_hit;

  always_comb begin
    if (char_height_q == gbr_pkg::HEIGHT_SMALL || char_height_q == gbr_pkg::HEIGHT_LARGE) begin
      total = char_height_q;
    end else begin
      total = 5'd0;
    end
    y_e   = first_q ? start_y_q : cursor_y_q;
    top_e = first_q ? start_y_q : column_top_q;
    bd_e  = first_q ? 5'd0 : bytes_done_q;
    act_e = first_q ? (total != 5'd0) : char_active_q;
    draw  = act_e && (total != 5'd0) && (bd_e < total);

    // Bits walked before the column completes or the bottom edge is reached.
    d0      = y_e - top_e;
    col_rem = char_height_q - d0[4:0];
    if ({4'd0, char_height_q} > d0) begin
      n_col = (col_rem > 5'd8) ? gbr_pkg::BYTE_BITS : col_rem[3:0];
    end else begin
      n_col = gbr_pkg::BYTE_BITS;
    end
    bot_rem = gbr_pkg::DISPLAY_HEIGHT - {1'b0, y_e};
    if ({1'b0, y_e} < gbr_pkg::DISPLAY_HEIGHT) begin
      n_bot = (bot_rem > 10'd8) ? gbr_pkg::BYTE_BITS : bot_rem[3:0];
    end else begin
      n_bot = 4'd1;
    end
    n_steps   = (n_col < n_bot) ? n_col : n_bot;
    walk_mask = ~(8'hFF >> n_steps);
  end

  always_comb begin
    emit     = emask_q[7];
    out_free = !out_valid_q || out_ready_i;
    advance  = cmd_i.step && !(emit && !out_free);
    out_load = advance && emit;

    ny        = {1'b0, cursor_y_q} + 10'd1;
    ny_off    = ny[8:0] - column_top_q;
    nx        = {1'b0, cursor_x_q} + 10'd1;
    bot_hit   = (ny >= gbr_pkg::DISPLAY_HEIGHT);
    col_hit   = (ny_off == {4'd0, char_height_q});
    right_hit = (nx >= gbr_pkg::DISPLAY_WIDTH);

    stat_o.draw       = draw;
    stat_o.emit_block = emit && !out_free;
    stat_o.loop_end   = bot_hit || col_hit || (cnt_q == 3'd7);
  end

  always_comb begin
    cursor_x_d    = cursor_x_q;
    cursor_y_d    = cursor_y_q;
    column_top_d  = column_top_q;
    bytes_done_d  = bytes_done_q;
    char_active_d = char_active_q;
    bits_d        = bits_q;
    emask_d       = emask_q;
    cnt_d         = cnt_q;
    if (cmd_i.load) begin
      if (first_q) begin
        cursor_x_d   = start_x_q;
        cursor_y_d   = start_y_q;
        column_top_d = start_y_q;
      end
      char_active_d = act_e;
      bytes_done_d  = draw ? bd_e + 5'd1 : bd_e;
      emask_d       = (transparent_q ? bits_q : 8'hFF) & walk_mask;
      cnt_d         = 3'd0;
    end else if (advance) begin
      bits_d  = {bits_q[6:0], 1'b0};
      emask_d = {emask_q[6:0], 1'b0};
      cnt_d   = cnt_q + 3'd1;
      if (bot_hit) begin
        char_active_d = 1'b0;
      end else if (col_hit) begin
        cursor_y_d = column_top_q;
        if (right_hit) begin
          char_active_d = 1'b0;
        end else begin
          cursor_x_d = nx[8:0];
        end
      end else begin
        cursor_y_d = ny[8:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_height_q <= gbr_pkg::RST_CHAR_HEIGHT;
      transparent_q <= 1'b0;
      text_color_q  <= gbr_pkg::RST_TEXT_COLOR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbr_pkg::REG_CHAR_HEIGHT: char_height_q <= cfg_wdata_i[4:0];
        gbr_pkg::REG_TRANSPARENT: transparent_q <= cfg_wdata_i[0];
        gbr_pkg::REG_TEXT_COLOR:  text_color_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q    <= 9'd0;
      cursor_y_q    <= 9'd0;
      column_top_q  <= 9'd0;
      bytes_done_q  <= 5'd0;
      char_active_q <= 1'b0;
      emask_q       <= 8'd0;
      cnt_q         <= 3'd0;
      out_valid_q   <= 1'b0;
    end else begin
      cursor_x_q    <= cursor_x_d;
      cursor_y_q    <= cursor_y_d;
      column_top_q  <= column_top_d;
      bytes_done_q  <= bytes_done_d;
      char_active_q <= char_active_d;
      emask_q       <= emask_d;
      cnt_q         <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      bits_q    <= glyph_bits_i;
      first_q   <= first_byte_i;
      start_x_q <= start_x_i;
      start_y_q <= start_y_i;
    end else begin
      bits_q <= bits_d;
    end
    if (out_load) begin
      px_q <= cursor_x_q;
      py_q <= cursor_y_q;
      pc_q <= bits_q[7] ? text_color_q : 16'd0;
      pl_q <= (emask_q[6:0] == 7'd0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pc_q;
  assign run_last_o    = pl_q;

endmodule

`default_nettype wire

// ===== rtl/core/gbr_checker.sv =====
`default_nettype none

module gbr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [8:0]  pixel_x_o,
  input wire logic [8:0]  pixel_y_o,
  input wire logic [15:0] pixel_color_o,
  input wire logic        run_last_o
);

  // Taking an item is always followed by its decision state, so input is not ready right after.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after an item was taken");

  // A waiting pixel holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(pixel_x_o)
      && $stable(pixel_y_o) && $stable(pixel_color_o) && $stable(run_last_o)))
    else $error("stalled pixel changed");

  // While a pixel that is not its item's last waits, that item is still walking.
  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !run_last_o) |-> !in_ready_o)
    else $error("new item taken before the previous run ended");

endmodule

bind glyph_bitmap_rasterizer_core gbr_checker u_gbr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_x_o     (pixel_x_o),
  .pixel_y_o     (pixel_y_o),
  .pixel_color_o (pixel_color_o),
  .run_last_o    (run_last_o)
);

`default_nettype wire
